FILE: hw/rtl/bell_number_triangle_defines.svh
// ----------------------------------------------------------------------------
// Bell number triangle assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BELL_NUMBER_TRIANGLE_DEFINES_SVH
`define BELL_NUMBER_TRIANGLE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BNT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BNT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bnt_pkg.sv
// ----------------------------------------------------------------------------
// Bell number triangle package
// Index width, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package bnt_pkg;

	localparam int IDX_W = 6;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INIT  = 5'b00010,
		ST_ROW   = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_DONE  = 5'b10000
	} bnt_state_t;

	typedef struct packed {
		logic             acc_init;
		logic             wr_acc;
		logic             add_wr;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} bnt_cmd_t;

endpackage

FILE: hw/rtl/bnt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module bnt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 58
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bnt_ctrl.sv
// ----------------------------------------------------------------------------
// Bell number triangle controller
// Sequences the row builds and sweeps and issues datapath commands.
// ----------------------------------------------------------------------------
module bnt_ctrl import bnt_pkg::*; #(
	parameter int MAX_INDEX = 58
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] index_n,
	output logic             busy,
	output logic             done,
	output bnt_cmd_t         cmd
);

	localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_TWO = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_INDEX);

	bnt_state_t       state_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] n_sat;

	assign n_sat = (index_n > IDX_MAX) ? IDX_MAX : index_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= n_sat;
						state_q <= (n_sat < IDX_TWO) ? ST_DONE : ST_INIT;
					end
				end
				ST_INIT: begin
					i_q     <= IDX_ONE;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					k_q     <= i_q - IDX_ONE;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (k_q != '0) begin
						k_q <= k_q - IDX_ONE;
					end else if (i_q + IDX_ONE == n_q) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q + IDX_ONE;
						state_q <= ST_ROW;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.acc_init = start;
			end
			ST_INIT: begin
				cmd.wr_acc = 1'b1;
			end
			ST_ROW: begin
				cmd.wr_acc  = 1'b1;
				cmd.wr_addr = i_q;
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = i_q - IDX_ONE;
			end
			ST_SWEEP: begin
				cmd.add_wr  = 1'b1;
				cmd.wr_addr = k_q;
				cmd.rd_en   = (k_q != '0);
				cmd.rd_addr = k_q - IDX_ONE;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

FILE: hw/rtl/bnt_datapath.sv
// ----------------------------------------------------------------------------
// Bell number triangle datapath
// Running-sum accumulator and the three limb RAMs of the working row.
// ----------------------------------------------------------------------------
module bnt_datapath import bnt_pkg::*; #(
	parameter int MAX_INDEX = 58,
	parameter int LIMB_BITS = 64
) (
	input  logic                     clk,
	input  bnt_cmd_t                 cmd,
	output logic [3*LIMB_BITS-1:0]   acc
);

	localparam int ACC_W = 3 * LIMB_BITS;
	localparam int AW    = (MAX_INDEX > 1) ? $clog2(MAX_INDEX) : 1;

	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     rd_word;
	logic [ACC_W-1:0]     sum;
	logic [ACC_W-1:0]     wr_word;
	logic                 wr_en;
	logic [LIMB_BITS-1:0] rd_low;
	logic [LIMB_BITS-1:0] rd_mid;
	logic [LIMB_BITS-1:0] rd_high;

	assign rd_word = {rd_high, rd_mid, rd_low};
	assign sum     = rd_word + acc_q;
	assign wr_word = cmd.add_wr ? sum : acc_q;
	assign wr_en   = cmd.wr_acc | cmd.add_wr;

	// acc carries entry 0 between rows and the running sum within a sweep
	always_ff @(posedge clk) begin
		if (cmd.acc_init) begin
			acc_q <= ACC_W'(1);
		end else if (cmd.add_wr) begin
			acc_q <= sum;
		end
	end

	bnt_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_INDEX)) u_row_low (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd.wr_addr[AW-1:0]),
		.wdata (wr_word[LIMB_BITS-1:0]),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr[AW-1:0]),
		.rdata (rd_low)
	);

	bnt_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_INDEX)) u_row_mid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd.wr_addr[AW-1:0]),
		.wdata (wr_word[2*LIMB_BITS-1:LIMB_BITS]),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr[AW-1:0]),
		.rdata (rd_mid)
	);

	bnt_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_INDEX)) u_row_high (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd.wr_addr[AW-1:0]),
		.wdata (wr_word[ACC_W-1:2*LIMB_BITS]),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr[AW-1:0]),
		.rdata (rd_high)
	);

	assign acc = acc_q;

endmodule

FILE: hw/rtl/bell_number_triangle.sv
// Each row is swept with one 192-bit add per cycle through the working-row RAM read port.
// A new item is taken the cycle after done, so items never overlap.
// The receiver cannot stall: done is a one-cycle strobe with the limbs valid alongside.
// Reset clears the controller only; the row RAMs are not cleared.
// ----------------------------------------------------------------------------
// Bell number triangle
// Computes B(n) as three 64-bit limbs by building the Bell triangle in place.
// ----------------------------------------------------------------------------
`include "bell_number_triangle_defines.svh"

module bell_number_triangle import bnt_pkg::*; #(
	parameter int MAX_INDEX = 58,
	parameter int LIMB_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [IDX_W-1:0]     index_n,
	output logic                 done,
	output logic [LIMB_BITS-1:0] bell_limb_low,
	output logic [LIMB_BITS-1:0] bell_limb_mid,
	output logic [LIMB_BITS-1:0] bell_limb_high
);

	bnt_cmd_t               cmd;
	logic [3*LIMB_BITS-1:0] acc;

	bnt_ctrl #(.MAX_INDEX(MAX_INDEX)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.index_n (index_n),
		.busy    (busy),
		.done    (done),
		.cmd     (cmd)
	);

	bnt_datapath #(.MAX_INDEX(MAX_INDEX), .LIMB_BITS(LIMB_BITS)) u_datapath (
		.clk (clk),
		.cmd (cmd),
		.acc (acc)
	);

	assign bell_limb_low  = acc[LIMB_BITS-1:0];
	assign bell_limb_mid  = acc[2*LIMB_BITS-1:LIMB_BITS];
	assign bell_limb_high = acc[3*LIMB_BITS-1:2*LIMB_BITS];

	`BNT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	`BNT_ASSERT_SAME(a_done_busy, done, busy, "done outside of busy")
	`BNT_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done not a single pulse")
	`BNT_ASSERT_SAME(a_cmd_excl, busy, !(cmd.wr_acc && cmd.add_wr), "two writes in one cycle")

endmodule

FILE: tb/bell_number_triangle_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bell number triangle testbench
// Sends indexes through the start/busy handshake and checks every done strobe
// against B(n), which a local Bell triangle computes at 192 bits. A directed
// pass covers the index extremes and saturation. Three random passes follow,
// with the sender idling seldom, often and not at all.
// ----------------------------------------------------------------------------
module bell_number_triangle_tb import bnt_pkg::*;;

	localparam int BELL_MAX_INDEX = 58;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 1800;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [IDX_W-1:0]     index_n = '0;
	logic                 busy;
	logic                 done;
	logic [63:0]          bell_limb_low;
	logic [63:0]          bell_limb_mid;
	logic [63:0]          bell_limb_high;

	logic [191:0]         pending_bells[$];
	logic [191:0]         want_bell;
	int                   mismatch_count = 0;
	int                   stall_cycles = 0;
	int                   idle_pct = 0;

	bell_number_triangle u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.index_n        (index_n),
		.done           (done),
		.bell_limb_low  (bell_limb_low),
		.bell_limb_mid  (bell_limb_mid),
		.bell_limb_high (bell_limb_high)
	);

	always #5 clk = ~clk;

	// B(n) by the Bell triangle, index saturated at the maximum
	function automatic logic [191:0] bell_value(input logic [IDX_W-1:0] idx);
		logic [191:0] row [BELL_MAX_INDEX];
		int           n;
		n = int'(idx);
		if (n > BELL_MAX_INDEX)
			n = BELL_MAX_INDEX;
		row[0] = 192'd1;
		for (int i = 1; i < n; i++) begin
			row[i] = row[0];
			for (int k = i; k >= 1; k--)
				row[k-1] = row[k-1] + row[k];
		end
		return row[0];
	endfunction

	task automatic check_limb(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// result checker, expectation capture and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_bells.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h %h %h",
						$time, bell_limb_high, bell_limb_mid, bell_limb_low);
					mismatch_count++;
				end else begin
					want_bell = pending_bells.pop_front();
					check_limb("bell_limb_low", want_bell[63:0], bell_limb_low);
					check_limb("bell_limb_mid", want_bell[127:64], bell_limb_mid);
					check_limb("bell_limb_high", want_bell[191:128], bell_limb_high);
				end
			end
			if (start && !busy)
				pending_bells.push_back(bell_value(index_n));
			if (done || (start && !busy)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// one item; start stays high after accept so back-to-back items need no gap
	task automatic send_index(input logic [IDX_W-1:0] value);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start   <= 1'b1;
		index_n <= value;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_bells.size() != 0);
	endtask

	// mostly small indexes, a few near and above the maximum
	function automatic logic [IDX_W-1:0] random_index();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return IDX_W'($urandom_range(12));
		else if (r < 92)
			return IDX_W'($urandom_range(40, 13));
		else
			return IDX_W'($urandom_range(63, 41));
	endfunction

	task automatic test_directed();
		logic [IDX_W-1:0] list [$];
		list = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd8, 6'd16, 6'd31, 6'd32,
			6'd21, 6'd42, 6'd57, 6'd58, 6'd59, 6'd62, 6'd63, 6'd1, 6'd0, 6'd58};
		idle_pct = 0;
		foreach (list[i])
			send_index(list[i]);
		drain_results();
	endtask

	task automatic test_random(input int pct, input int count);
		idle_pct = pct;
		repeat (count)
			send_index(random_index());
		drain_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(20, 120);
		test_random(71, 115);
		test_random(0, 115);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
